### rtl/xorshift_range_generator_macros.svh
// assertion macros used by the range generator sequencer
`ifndef XORSHIFT_RANGE_GENERATOR_MACROS_SVH
`define XORSHIFT_RANGE_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define XRG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xrg check failed");

// next-cycle implication, checked outside reset
`define XRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("xrg check failed");

`endif

### rtl/xrg_pkg.sv
// shared constants, types and the xorshift step for the range generator
package xrg_pkg;

    localparam int WORD_W    = 32;
    localparam int DIV_W     = WORD_W + 1;
    localparam int DIV_STEPS = WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    localparam logic [WORD_W-1:0] SEED_RESET = 32'd1;

    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;

    typedef struct packed {
        logic load;    // capture a word and advance the generator
        logic prep;    // set up divisor, dividend and offset
        logic step;    // one restoring division step
        logic finish;  // write the output register
    } t_dp_cmd;

    typedef struct packed {
        logic zero_width;
        logic last_step;
    } t_dp_status;

    function automatic logic [WORD_W-1:0] xs_next(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] x;
        x = s;
        x = x ^ (x << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ (x << SHIFT_C);
        return x;
    endfunction

endpackage

### rtl/xrg_datapath.sv
// generator state, range setup, radix-2 remainder unit and output register
module xrg_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [xrg_pkg::WORD_W-1:0]   i_cfg_wr_data,
    input  logic                         i_cmd,
    input  logic [xrg_pkg::WORD_W-1:0]   i_bound_a,
    input  logic [xrg_pkg::WORD_W-1:0]   i_bound_b,
    input  xrg_pkg::t_dp_cmd             i_dp_cmd,
    output xrg_pkg::t_dp_status          o_dp_status,
    output logic [xrg_pkg::WORD_W-1:0]   o_value,
    output logic [xrg_pkg::WORD_W-1:0]   o_raw_word
);
    import xrg_pkg::*;

    logic [WORD_W-1:0] r_state, n_state;
    logic [WORD_W-1:0] r_x;
    logic              r_cmd;
    logic [WORD_W-1:0] r_a, r_b;
    logic [DIV_W-1:0]  r_div, n_div;
    logic [WORD_W-1:0] r_lo, n_lo;
    logic              r_zero, n_zero;
    logic [DIV_W-1:0]  r_rem;
    logic [WORD_W-1:0] r_dvd, n_dvd;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_value, r_raw;

    logic [WORD_W-1:0] w_unsigned;
    logic [DIV_W:0]    sa_ext, sb_ext, wide_s, wide_abs;
    logic [WORD_W-1:0] mag;
    logic [DIV_W:0]    shifted;
    logic [DIV_W+1:0]  diff;

    // generator state: config load wins, else advance on a new word
    always_comb begin
        n_state = r_state;
        if (i_cfg_wr_en) begin
            n_state = i_cfg_wr_data;
        end else if (i_dp_cmd.load) begin
            n_state = xs_next(r_state);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEED_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    // range setup
    always_comb begin
        w_unsigned = r_b - r_a + WORD_W'(1);
        sa_ext     = {{2{r_a[WORD_W-1]}}, r_a};
        sb_ext     = {{2{r_b[WORD_W-1]}}, r_b};
        wide_s     = sb_ext - sa_ext + (DIV_W+1)'(1);
        wide_abs   = wide_s[DIV_W] ? (~wide_s + (DIV_W+1)'(1)) : wide_s;
        // most negative word maps to 2^31, which fits unsigned
        mag        = r_x[WORD_W-1] ? (~r_x + WORD_W'(1)) : r_x;
        unique case (r_cmd)
            CMD_UNSIGNED: begin
                n_div  = {1'b0, w_unsigned};
                n_dvd  = r_x;
                n_lo   = r_a;
                n_zero = (w_unsigned == '0);
            end
            CMD_SIGNED: begin
                n_div  = wide_abs[DIV_W-1:0];
                n_dvd  = mag;
                n_lo   = ($signed(r_a) < $signed(r_b)) ? r_a : r_b;
                n_zero = (wide_abs == '0);
            end
            default: begin
                n_div  = {1'b0, w_unsigned};
                n_dvd  = r_x;
                n_lo   = r_a;
                n_zero = (w_unsigned == '0);
            end
        endcase
    end

    // restoring step: bring in one dividend bit, subtract if it fits
    always_comb begin
        shifted = {r_rem, r_dvd[WORD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_x   <= xs_next(r_state);
            r_cmd <= i_cmd;
            r_a   <= i_bound_a;
            r_b   <= i_bound_b;
        end
        if (i_dp_cmd.prep) begin
            r_div  <= n_div;
            r_dvd  <= n_dvd;
            r_lo   <= n_lo;
            r_zero <= n_zero;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_dp_cmd.step) begin
            r_rem <= diff[DIV_W+1] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_dp_cmd.finish) begin
            r_value <= r_zero ? r_x : (r_rem[WORD_W-1:0] + r_lo);
            r_raw   <= r_x;
        end
    end

    assign o_dp_status.zero_width = r_zero;
    assign o_dp_status.last_step  = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_value    = r_value;
    assign o_raw_word = r_raw;

endmodule

### rtl/xrg_ctrl.sv
// sequencer for one draw: accept, setup, divide, deliver
`include "xorshift_range_generator_macros.svh"

module xrg_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  xrg_pkg::t_dp_status  i_dp_status,
    output xrg_pkg::t_dp_cmd     o_dp_cmd
);
    import xrg_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_fsm, n_fsm;
    logic       r_out_valid, n_out_valid;
    logic       in_acc, out_free;

    assign o_stall  = (r_fsm != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    // output register can take a word when empty or being drained
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_fsm           = r_fsm;
        n_out_valid     = r_out_valid && i_stall;
        o_dp_cmd        = '0;
        o_dp_cmd.load   = in_acc;
        unique case (r_fsm)
            S_IDLE: begin
                if (in_acc) begin
                    n_fsm = S_PREP;
                end
            end
            S_PREP: begin
                o_dp_cmd.prep = 1'b1;
                n_fsm = S_DIV;
            end
            S_DIV: begin
                if (i_dp_status.zero_width) begin
                    n_fsm = S_FIN;
                end else begin
                    o_dp_cmd.step = 1'b1;
                    if (i_dp_status.last_step) begin
                        n_fsm = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_dp_cmd.finish = 1'b1;
                    n_out_valid     = 1'b1;
                    n_fsm           = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    `XRG_ASSERT_NEXT(a_accept_to_prep, in_acc, r_fsm == S_PREP)
    `XRG_ASSERT_NEXT(a_last_to_fin, (r_fsm == S_DIV) && i_dp_status.last_step, r_fsm == S_FIN)
    `XRG_ASSERT_NEXT(a_fin_delivers, (r_fsm == S_FIN) && out_free,
                     r_out_valid && (r_fsm == S_IDLE))
    `XRG_ASSERT_NOW(a_no_step_on_zero, i_dp_status.zero_width && (r_fsm == S_DIV),
                    !o_dp_cmd.step)

endmodule

### rtl/xorshift_range_generator.sv
// top level of the xorshift range generator
// Usage:
//   Input channel i_valid/o_stall carries one word: i_cmd, i_bound_a, i_bound_b.
//   Output channel o_valid/i_stall carries o_value and o_raw_word.
//   i_cfg_wr_en with i_cfg_wr_data loads the generator state (seed).
//   Each accepted word advances the xorshift state, then reduces the new
//   value into the bound interval (cmd 0 unsigned, cmd 1 signed).
//   From accept to o_valid a word passes a setup state, 32 steps
//   of the radix-2 remainder unit and a final state that writes the output register;
//   a zero-width interval skips the division steps.
//   The remainder loop yields one bit per cycle; o_stall is high from
//   accept until the result is written, so no new word is taken before.
//   The output register lets a new word be taken while the last result waits;
//   a stalled receiver holds the result and, if a second one is finished,
//   the sequencer waits in its final state until the register frees.
//   Synchronous active-low reset loads a seed of 1 and empties the output.
module xorshift_range_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [xrg_pkg::WORD_W-1:0]  i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_cmd,
    input  logic [xrg_pkg::WORD_W-1:0]  i_bound_a,
    input  logic [xrg_pkg::WORD_W-1:0]  i_bound_b,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [xrg_pkg::WORD_W-1:0]  o_value,
    output logic [xrg_pkg::WORD_W-1:0]  o_raw_word
);
    import xrg_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    xrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_dp_status (dp_status),
        .o_dp_cmd    (dp_cmd)
    );

    xrg_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (i_cmd),
        .i_bound_a     (i_bound_a),
        .i_bound_b     (i_bound_b),
        .i_dp_cmd      (dp_cmd),
        .o_dp_status   (dp_status),
        .o_value       (o_value),
        .o_raw_word    (o_raw_word)
    );

endmodule
